### hdl/btpd_pkg.sv
`timescale 1ns / 1ps

package btpd_pkg;

    // Defaults of the top-level parameters.
    localparam int DEF_NUM_CHANNELS     = 256;
    localparam int DEF_BLOCK_INDEX_BITS = 16;

    // The channel field is eight bits wide, so no more entries can ever be addressed.
    localparam int MAX_CHANNELS = 256;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AVERAGE_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRE_SAMPLES    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_POST_SAMPLES   = 2'd3;

    localparam logic [30:0] THRESHOLD_RESET      = 31'd65536;
    localparam logic [15:0] AVERAGE_LENGTH_RESET = 16'd1000;
    localparam logic [11:0] PRE_SAMPLES_RESET    = 12'd16;
    localparam logic [11:0] POST_SAMPLES_RESET   = 12'd16;

    // Baseline accumulator width and the number of restoring division steps.
    localparam int SUM_W     = 48;
    localparam int DIV_STEPS = SUM_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_PREP,
        ST_DIV
    } state_t;

endpackage

### hdl/btpd_if.sv
`timescale 1ns / 1ps

// Sample channel into the detector.
interface btpd_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         channel;
    logic signed [31:0] phase_sample;
    logic [15:0]        sample_index;
    logic [16:0]        block_length;
    logic               last_in_block;

    modport source (
        output valid, channel, phase_sample, sample_index, block_length, last_in_block,
        input  ready
    );
    modport sink (
        input  valid, channel, phase_sample, sample_index, block_length, last_in_block,
        output ready
    );
endinterface

// Pulse result channel out of the detector.
interface btpd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pulse_channel;
    logic [15:0] window_start;
    logic [16:0] window_end;
    logic [31:0] pulse_id;

    modport source (
        output valid, pulse_channel, window_start, window_end, pulse_id,
        input  ready
    );
    modport sink (
        input  valid, pulse_channel, window_start, window_end, pulse_id,
        output ready
    );
endinterface

### hdl/btpd_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered read data.
module btpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read; a read of the entry being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### hdl/baseline_threshold_pulse_detector.sv
`timescale 1ns / 1ps
// A result goes from the state RAM read into the output register; ST_EXEC waits while that
// register is stalled. Samples are taken one at a time (accept, then read-modify-write of
// the channel entry in the state RAM); an out-of-range channel is dropped. The sample that
// completes a baseline also passes a set-up state and the 48-step restoring divider. Reset:
// asynchronous, active low; a clearing pass then zeroes the min(NUM_CHANNELS, 256) state
// RAM entries, one entry a cycle, with ready low; configuration writes still land.
module baseline_threshold_pulse_detector #(
    parameter int NUM_CHANNELS     = btpd_pkg::DEF_NUM_CHANNELS,
    parameter int BLOCK_INDEX_BITS = btpd_pkg::DEF_BLOCK_INDEX_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [btpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [btpd_pkg::CFG_DATA_W-1:0]    cfg_data,
    btpd_in_if.sink                            samples,
    btpd_out_if.source                         pulses
);
    import btpd_pkg::*;

    localparam int DEPTH  = NUM_CHANNELS < MAX_CHANNELS ? NUM_CHANNELS : MAX_CHANNELS;
    localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int SW     = BLOCK_INDEX_BITS < 16 ? BLOCK_INDEX_BITS : 16;
    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [12:0]       CH_LIMIT  = 13'(NUM_CHANNELS);

    // One state RAM entry per channel.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [15:0]      count;
        logic [31:0]      baseline;
        logic             in_pulse;
        logic [SW-1:0]    start;
    } entry_t;

    localparam int EW = $bits(entry_t);

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg;

    // Configuration registers.
    logic [30:0] threshold_reg;
    logic [15:0] avg_len_reg;
    logic [11:0] pre_reg;
    logic [11:0] post_reg;

    // Captured sample.
    logic [7:0]  ch_reg;
    logic [31:0] x_reg;
    logic [15:0] idx_reg;
    logic [16:0] blen_reg;
    logic        last_reg;

    // Output register and pulse counter.
    logic        o_valid_reg;
    logic [7:0]  o_ch_reg;
    logic [15:0] o_ws_reg;
    logic [16:0] o_we_reg;
    logic [31:0] o_num_reg;
    logic [31:0] pulse_count_reg;

    // Divider.
    entry_t           entry_reg;
    logic             neg_reg;
    logic [SUM_W-1:0] dq_reg;
    logic [15:0]      rem_reg;
    logic [STEP_W-1:0] step_reg;

    // RAM port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    // Update logic signals.
    entry_t           cur;
    entry_t           upd;
    entry_t           div_entry;
    logic [SUM_W-1:0] sum_n;
    logic [15:0]      cnt_n;
    logic [32:0]      dev_d;
    logic [32:0]      dev_abs;
    logic             averaging;
    logic             over;
    logic             close_dev;
    logic             close_last;
    logic             emit;
    logic             need_div;
    logic             exec_go;
    logic [15:0]      start16;
    logic [15:0]      pre16;
    logic [15:0]      ws;
    logic [16:0]      end17;
    logic [17:0]      we18;
    logic [16:0]      we17;
    logic [16:0]      trial;
    logic             ge;
    logic [15:0]      rem_n;
    logic [31:0]      q32;
    logic             in_acc;
    logic             in_range;

    assign samples.ready = (state_reg == ST_IDLE);
    assign in_acc        = samples.valid && samples.ready;
    assign in_range      = 13'(samples.channel) < CH_LIMIT;

    assign ram_raddr = (state_reg == ST_IDLE) ? samples.channel[AW-1:0] : ch_reg[AW-1:0];
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : ch_reg[AW-1:0];

    btpd_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Per-sample update of the channel entry.
    always_comb
    begin
        cur       = entry_t'(ram_rdata);
        upd       = cur;
        close_dev = 1'b0;
        averaging = cur.count < avg_len_reg;
        sum_n     = cur.sum + {{(SUM_W - 32){x_reg[31]}}, x_reg};
        cnt_n     = cur.count + 16'd1;
        dev_d     = {x_reg[31], x_reg} - {cur.baseline[31], cur.baseline};
        dev_abs   = dev_d[32] ? -dev_d : dev_d;
        over      = dev_abs > {2'b00, threshold_reg};

        if (averaging)
        begin
            upd.sum   = sum_n;
            upd.count = cnt_n;
        end
        else if (!cur.in_pulse)
        begin
            if (over)
            begin
                upd.in_pulse = 1'b1;
                upd.start    = idx_reg[SW-1:0];
            end
        end
        else if (!over)
        begin
            upd.in_pulse = 1'b0;
            close_dev    = 1'b1;
        end

        // A pulse still open on the last sample of the block closes there.
        close_last = !close_dev && last_reg && upd.in_pulse;
        if (close_last)
        begin
            upd.in_pulse = 1'b0;
        end

        emit     = close_dev || close_last;
        need_div = averaging && (cnt_n >= avg_len_reg);
        exec_go  = !emit || !o_valid_reg || pulses.ready;
    end

    // Window limits of the pulse being closed.
    always_comb
    begin
        start16 = 16'(upd.start);
        pre16   = {4'd0, pre_reg};
        ws      = (start16 > pre16) ? (start16 - pre16) : 16'd0;
        end17   = close_dev ? {1'b0, idx_reg} : blen_reg;
        we18    = {1'b0, end17} + {6'd0, post_reg};
        we17    = (we18 > {1'b0, blen_reg}) ? blen_reg : we18[16:0];
    end

    // One restoring division step, and the signed baseline after the last one.
    always_comb
    begin
        trial     = {rem_reg, dq_reg[SUM_W-1]};
        ge        = trial >= {1'b0, entry_reg.count};
        rem_n     = ge ? 16'(trial - {1'b0, entry_reg.count}) : trial[15:0];
        q32       = {dq_reg[30:0], ge};
        div_entry = entry_reg;
        div_entry.baseline = neg_reg ? -q32 : q32;
    end

    // Next state and RAM write control.
    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_wdata  = ram_rdata;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc && in_range)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    if (need_div)
                    begin
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = upd;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = div_entry;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register and clearing counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            avg_len_reg   <= AVERAGE_LENGTH_RESET;
            pre_reg       <= PRE_SAMPLES_RESET;
            post_reg      <= POST_SAMPLES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD:      threshold_reg <= cfg_data;
                REG_AVERAGE_LENGTH: avg_len_reg   <= cfg_data[15:0];
                REG_PRE_SAMPLES:    pre_reg       <= cfg_data[11:0];
                REG_POST_SAMPLES:   post_reg      <= cfg_data[11:0];
                default:            ;
            endcase
        end
    end

    // Capture of the accepted sample.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ch_reg   <= samples.channel;
            x_reg    <= samples.phase_sample;
            idx_reg  <= samples.sample_index;
            blen_reg <= samples.block_length;
            last_reg <= samples.last_in_block;
        end
    end

    // Output register: a new result loads when the slot is free or is being emptied.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg     <= 1'b0;
            pulse_count_reg <= '0;
        end
        else if (state_reg == ST_EXEC && exec_go && emit)
        begin
            o_valid_reg     <= 1'b1;
            pulse_count_reg <= pulse_count_reg + 32'd1;
        end
        else if (pulses.ready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC && exec_go && emit)
        begin
            o_ch_reg  <= ch_reg;
            o_ws_reg  <= ws;
            o_we_reg  <= we17;
            o_num_reg <= pulse_count_reg;
        end
    end

    // Divider: hold the updated entry, form the rounded magnitude, then shift it through.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_EXEC:
            begin
                entry_reg <= upd;
            end
            ST_PREP:
            begin
                neg_reg  <= entry_reg.sum[SUM_W-1];
                dq_reg   <= (entry_reg.sum[SUM_W-1] ? ~entry_reg.sum : entry_reg.sum)
                            + SUM_W'(entry_reg.count[15:1])
                            + SUM_W'(entry_reg.sum[SUM_W-1]);
                rem_reg  <= '0;
                step_reg <= '0;
            end
            ST_DIV:
            begin
                dq_reg   <= {dq_reg[SUM_W-2:0], ge};
                rem_reg  <= rem_n;
                step_reg <= step_reg + STEP_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign pulses.valid         = o_valid_reg;
    assign pulses.pulse_channel = o_ch_reg;
    assign pulses.window_start  = o_ws_reg;
    assign pulses.window_end    = o_we_reg;
    assign pulses.pulse_id      = o_num_reg;
endmodule

### hdl/btpd_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the pulse detector.
module btpd_checker #(
    parameter int NUM_CHANNELS = btpd_pkg::DEF_NUM_CHANNELS
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  in_channel,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_pulse_channel,
    input logic [15:0] out_window_start,
    input logic [16:0] out_window_end,
    input logic [31:0] out_pulse_id
);
    logic        in_acc;
    logic        out_acc;
    logic        in_range;
    logic [31:0] expect_reg;

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign in_range = 13'(in_channel) < 13'(NUM_CHANNELS);

    // Pulse number the next result must carry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_reg <= '0;
        end
        else if (out_acc)
        begin
            expect_reg <= out_pulse_id + 32'd1;
        end
    end

    // A sample for a real channel is worked on before the next one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_range |=> !in_ready)
        else $error("sample taken while the previous one is still in work");

    // A result that appears in an empty slot comes from a sample taken, then updated in ST_EXEC.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_acc, 2))
        else $error("result appeared without a matching sample transaction");

    // Pulse numbers run on by one from result to result.
    a_pulse_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_pulse_id == expect_reg)
        else $error("pulse number out of sequence");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({out_pulse_channel,
            out_window_start, out_window_end, out_pulse_id}))
        else $error("stalled result changed");
endmodule

bind baseline_threshold_pulse_detector btpd_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_btpd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (samples.valid),
    .in_ready          (samples.ready),
    .in_channel        (samples.channel),
    .out_valid         (pulses.valid),
    .out_ready         (pulses.ready),
    .out_pulse_channel (pulses.pulse_channel),
    .out_window_start  (pulses.window_start),
    .out_window_end    (pulses.window_end),
    .out_pulse_id      (pulses.pulse_id)
);
